>>> hdl/trp_pkg.sv
// shared types and constants of the toggle packet receiver
`timescale 1ns / 1ps
`default_nettype none

package trp_pkg;

    // framing bytes
    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] PEER_ACK   = 8'h55;
    localparam logic [7:0] MIN_LEN    = 8'd5;

    // default largest frame length
    localparam int MAX_FRAME_DEF = 32;

    // positions of the header bytes inside a frame
    localparam int POS_START  = 0;
    localparam int POS_TOGGLE = 1;
    localparam int POS_CHECK  = 2;
    localparam int POS_LEN    = 3;
    localparam int POS_DATA   = 4;

    // crc-8, reflected polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // result kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_ACK_REQ  = 2'd1;
    localparam logic [1:0] KIND_PEER_ACK = 2'd2;

    // check modes
    localparam logic [1:0] MODE_EITHER = 2'd0;
    localparam logic [1:0] MODE_SUM    = 2'd1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_CHECK,
        S_LEN,
        S_READ,
        S_EMIT,
        S_ACK,
        S_PEER
    } state_t;

endpackage

`default_nettype wire

>>> hdl/toggle_packet_receiver_top.sv
// toggle packet receiver: framing, checksum check and payload replay
//
// Input channel in_valid/in_ready carries one received byte (rx_byte) with
// queue_has_room. A byte with queue_has_room low is taken and dropped.
// Output channel out_valid/out_ready carries results (kind, out_byte, last).
// check_mode is written through cfg_we/cfg_data; the user writes it only
// while the block is idle, the block itself does not enforce this. Each
// byte that enters the running checksum is taken, then its eight bits go
// through the bit-serial crc-8 shifter. Dropped or stray bytes are taken
// and leave the block idle. At the last byte of a good frame S_CHECK checks
// the checksum, then the length-3 byte, the payload and the ack request follow;
// each payload byte passes a read state and an emit state, as the frame
// memory has a registered read port. in_ready is low from taking a byte until
// its results are all loaded into the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears framing state, the expected toggle and check_mode; the
// frame memory needs no clearing, as every entry read was written first.
`timescale 1ns / 1ps
`default_nettype none

module toggle_packet_receiver_top #(
    parameter int MAX_FRAME = trp_pkg::MAX_FRAME_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       queue_has_room,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      out_byte,
    output logic            last
);

    localparam int IDX_W = $clog2(MAX_FRAME);
    localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME);

    // registers
    trp_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             tog_inv_reg, tog_inv_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       crc_data_reg, crc_data_next;
    logic [2:0]       bit_cnt_reg, bit_cnt_next;
    logic             end_reg, end_next;
    logic [7:0]       given_reg, given_next;
    logic [7:0]       len_reg, len_next;
    logic [1:0]       mode_reg;
    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic [7:0]       rd_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             last_reg, last_next;

    // frame memory
    logic [7:0] frame_mem [MAX_FRAME];

    // decode
    logic       accept;
    logic       slot_free;
    logic       at_start, at_toggle, at_check, at_len;
    logic [7:0] want_toggle;
    logic       len_bad;
    logic       frame_end;
    logic       crc_fb;
    logic       sum_ok, crc_ok, chk_ok;
    logic       rd_last;

    assign in_ready  = (state_reg == trp_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign at_start    = (idx_reg == IDX_W'(trp_pkg::POS_START));
    assign at_toggle   = (idx_reg == IDX_W'(trp_pkg::POS_TOGGLE));
    assign at_check    = (idx_reg == IDX_W'(trp_pkg::POS_CHECK));
    assign at_len      = (idx_reg == IDX_W'(trp_pkg::POS_LEN));
    assign want_toggle = {7'd0, ~tog_inv_reg};
    assign len_bad     = ({1'b0, rx_byte} > MAX_LEN) || (rx_byte < trp_pkg::MIN_LEN);
    assign frame_end   = !at_start && !at_toggle && !at_check && !at_len
                         && ((9'(idx_reg) + 9'd1) == {1'b0, len_reg});

    assign crc_fb = crc_reg[0] ^ crc_data_reg[0];
    assign sum_ok = (sum_reg == given_reg);
    assign crc_ok = (crc_reg == given_reg);
    assign rd_last = ((9'(rd_addr_reg) + 9'd1) == {1'b0, len_reg});

    // check result by mode
    always_comb
    begin
        case (mode_reg)
            trp_pkg::MODE_EITHER: chk_ok = sum_ok || crc_ok;
            trp_pkg::MODE_SUM:    chk_ok = sum_ok;
            default:              chk_ok = crc_ok;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trp_pkg::S_IDLE:
            begin
                if (accept && queue_has_room)
                begin
                    if (at_start)
                    begin
                        if (rx_byte == trp_pkg::START_BYTE)
                            state_next = trp_pkg::S_CRC;
                    end
                    else if (at_toggle)
                    begin
                        if (rx_byte == want_toggle)
                            state_next = trp_pkg::S_CRC;
                        else if (rx_byte == trp_pkg::PEER_ACK)
                            state_next = trp_pkg::S_PEER;
                    end
                    else if (at_len)
                    begin
                        if (!len_bad)
                            state_next = trp_pkg::S_CRC;
                    end
                    else
                        state_next = trp_pkg::S_CRC;
                end
            end
            trp_pkg::S_CRC:
            begin
                if (bit_cnt_reg == 3'd7)
                    state_next = end_reg ? trp_pkg::S_CHECK : trp_pkg::S_IDLE;
            end
            trp_pkg::S_CHECK:
                state_next = chk_ok ? trp_pkg::S_LEN : trp_pkg::S_IDLE;
            trp_pkg::S_LEN:
                if (slot_free)
                    state_next = trp_pkg::S_READ;
            trp_pkg::S_READ:
                state_next = trp_pkg::S_EMIT;
            trp_pkg::S_EMIT:
                if (slot_free)
                    state_next = rd_last ? trp_pkg::S_ACK : trp_pkg::S_READ;
            trp_pkg::S_ACK:
                if (slot_free)
                    state_next = trp_pkg::S_IDLE;
            trp_pkg::S_PEER:
                if (slot_free)
                    state_next = trp_pkg::S_IDLE;
            default:
                state_next = trp_pkg::S_IDLE;
        endcase
    end

    // datapath and result register next values
    always_comb
    begin
        idx_next       = idx_reg;
        tog_inv_next   = tog_inv_reg;
        sum_next       = sum_reg;
        crc_next       = crc_reg;
        crc_data_next  = crc_data_reg;
        bit_cnt_next   = bit_cnt_reg;
        end_next       = end_reg;
        given_next     = given_reg;
        len_next       = len_reg;
        rd_addr_next   = rd_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        case (state_reg)
            trp_pkg::S_IDLE:
            begin
                bit_cnt_next = 3'd0;
                end_next     = 1'b0;
                if (accept && queue_has_room)
                begin
                    if (at_start)
                    begin
                        if (rx_byte == trp_pkg::START_BYTE)
                        begin
                            idx_next      = IDX_W'(trp_pkg::POS_TOGGLE);
                            sum_next      = rx_byte;
                            crc_next      = 8'd0;
                            crc_data_next = rx_byte;
                        end
                    end
                    else if (at_toggle)
                    begin
                        if (rx_byte == want_toggle)
                        begin
                            idx_next      = IDX_W'(trp_pkg::POS_CHECK);
                            sum_next      = sum_reg + rx_byte;
                            crc_data_next = rx_byte;
                        end
                        else
                            idx_next = IDX_W'(trp_pkg::POS_START);
                    end
                    else if (at_check)
                    begin
                        // checksum byte counts as zero
                        idx_next      = IDX_W'(trp_pkg::POS_LEN);
                        given_next    = rx_byte;
                        crc_data_next = 8'd0;
                    end
                    else if (at_len)
                    begin
                        if (len_bad)
                            idx_next = IDX_W'(trp_pkg::POS_START);
                        else
                        begin
                            idx_next      = IDX_W'(trp_pkg::POS_DATA);
                            len_next      = rx_byte;
                            sum_next      = sum_reg + rx_byte;
                            crc_data_next = rx_byte;
                        end
                    end
                    else
                    begin
                        sum_next      = sum_reg + rx_byte;
                        crc_data_next = rx_byte;
                        end_next      = frame_end;
                        idx_next      = frame_end ? IDX_W'(trp_pkg::POS_START)
                                                  : idx_reg + IDX_W'(1);
                    end
                end
            end
            trp_pkg::S_CRC:
            begin
                // one bit of the crc-8 per cycle
                crc_next      = {1'b0, crc_reg[7:1]} ^ (crc_fb ? trp_pkg::CRC_POLY : 8'd0);
                crc_data_next = {1'b0, crc_data_reg[7:1]};
                bit_cnt_next  = bit_cnt_reg + 3'd1;
            end
            trp_pkg::S_CHECK:
            begin
                if (chk_ok)
                    tog_inv_next = !tog_inv_reg;
            end
            trp_pkg::S_LEN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = trp_pkg::KIND_DATA;
                    out_byte_next  = len_reg - 8'd3;
                    last_next      = 1'b0;
                    rd_addr_next   = IDX_W'(trp_pkg::POS_DATA);
                end
            end
            trp_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = trp_pkg::KIND_DATA;
                    out_byte_next  = rd_data_reg;
                    last_next      = 1'b0;
                    if (!rd_last)
                        rd_addr_next = rd_addr_reg + IDX_W'(1);
                end
            end
            trp_pkg::S_ACK:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = trp_pkg::KIND_ACK_REQ;
                    out_byte_next  = 8'd0;
                    last_next      = 1'b1;
                end
            end
            trp_pkg::S_PEER:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = trp_pkg::KIND_PEER_ACK;
                    out_byte_next  = 8'd0;
                    last_next      = 1'b1;
                end
            end
            default:
            begin
                end_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trp_pkg::S_IDLE;
            idx_reg       <= '0;
            tog_inv_reg   <= 1'b0;
            sum_reg       <= 8'd0;
            crc_reg       <= 8'd0;
            bit_cnt_reg   <= 3'd0;
            end_reg       <= 1'b0;
            mode_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            tog_inv_reg   <= tog_inv_next;
            sum_reg       <= sum_next;
            crc_reg       <= crc_next;
            bit_cnt_reg   <= bit_cnt_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                mode_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        crc_data_reg <= crc_data_next;
        given_reg    <= given_next;
        len_reg      <= len_next;
        rd_addr_reg  <= rd_addr_next;
        kind_reg     <= kind_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    // frame memory: data bytes written on arrival, registered read
    always_ff @(posedge clk)
    begin
        if (accept && queue_has_room && !at_start && !at_toggle && !at_check && !at_len)
            frame_mem[idx_reg] <= rx_byte;
        rd_data_reg <= frame_mem[rd_addr_reg];
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

>>> hdl/trp_checker.sv
// port-level checks of the toggle packet receiver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module trp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] kind,
    input wire logic [7:0] out_byte,
    input wire logic       last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
                                    && $stable(last))
        else $error("stalled result changed");

    // ack results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != trp_pkg::KIND_DATA |-> out_byte == 8'd0)
        else $error("ack result with non-zero byte");

    // only the ack results end an item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (kind != trp_pkg::KIND_DATA)))
        else $error("last flag does not match kind");

    // during payload replay no new item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == trp_pkg::KIND_DATA |-> !in_ready)
        else $error("item taken during replay");

endmodule

bind toggle_packet_receiver_top trp_checker u_trp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .last      (last)
);

`default_nettype wire
